### rtl/glu_pkg.sv
package glu_pkg;

    localparam logic FUNC_GCD = 1'b0;
    localparam logic FUNC_LCM = 1'b1;

    // Operations of the shared divide/multiply unit
    localparam logic [1:0] OP_DIV = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } glu_cmd_t;

endpackage

### rtl/glu_divmul.sv
// Shared radix-2 divider and shift-add multiplier, one bit per cycle.
module glu_divmul import glu_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  glu_cmd_t         cmd,
    input  logic [WIDTH-1:0] opa,
    input  logic [WIDTH-1:0] opb,
    output logic             done,
    output logic [WIDTH-1:0] quo,
    output logic [WIDTH-1:0] rem,
    output logic [2*WIDTH-1:0] prod
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         op_reg;
    logic [WIDTH-1:0]   a_reg;
    logic [WIDTH-1:0]   b_reg;
    logic [WIDTH:0]     r_reg;
    logic [2*WIDTH-1:0] p_reg;
    logic [WIDTH:0]     trial;

    assign trial = {r_reg[WIDTH-1:0], a_reg[WIDTH-1]} - {1'b0, b_reg};

    // Advance one bit per cycle; flag done once the last bit has landed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(WIDTH);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg <= cmd.op;
            a_reg  <= opa;
            b_reg  <= opb;
            r_reg  <= '0;
            p_reg  <= '0;
        end else if (busy_reg) begin
            case (op_reg)
                OP_DIV: begin
                    if (!trial[WIDTH]) begin
                        r_reg <= trial;
                        a_reg <= {a_reg[WIDTH-2:0], 1'b1};
                    end else begin
                        r_reg <= {r_reg[WIDTH-1:0], a_reg[WIDTH-1]};
                        a_reg <= {a_reg[WIDTH-2:0], 1'b0};
                    end
                end
                default: begin
                    p_reg <= {p_reg[2*WIDTH-2:0], 1'b0}
                           + (a_reg[WIDTH-1] ? {{WIDTH{1'b0}}, b_reg} : '0);
                    a_reg <= {a_reg[WIDTH-2:0], 1'b0};
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = a_reg;
    assign rem  = r_reg[WIDTH-1:0];
    assign prod = p_reg;

endmodule

### rtl/gcd_lcm_unit.sv
// Steps: a modulo of the larger operand by the smaller, the Stein loop, then for lcm a
// divide and a multiply, and last a load of the output register; gcd skips the divide
// and multiply, and a zero operand skips the modulo and the loop.
// Flow: one word is in work at a time; s_axis_tready is high only while the sequencer
// is idle, since the shared divide/multiply unit serves one word at a time.
// Reset: synchronous active-low aresetn clears the sequencer and output valid.
module gcd_lcm_unit import glu_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [2*WIDTH-1:0] s_axis_tdata,  // x, y
    input  logic           s_axis_tuser,      // func
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [WIDTH-1:0] m_axis_tdata,    // result
    output logic           m_axis_tuser       // overflow
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_STN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam int SW = $clog2(WIDTH + 1);

    logic [2:0]       state_reg;
    logic             func_reg;
    logic [WIDTH-1:0] ax_reg, ay_reg, big_reg, sml_reg;
    logic [SW-1:0]    com_reg;
    logic [WIDTH-1:0] res_reg;
    logic             ovf_reg;
    logic [WIDTH-1:0] mdata_reg;
    logic             muser_reg;
    glu_cmd_t         cmd;
    logic [WIDTH-1:0] opa, opb, quo, rem;
    logic [2*WIDTH-1:0] prod;
    logic             done;
    logic [WIDTH-1:0] mx, my, mbig, msml;

    assign mx   = s_axis_tdata[WIDTH-1] ? -s_axis_tdata[WIDTH-1:0] : s_axis_tdata[WIDTH-1:0];
    assign my   = s_axis_tdata[2*WIDTH-1] ? -s_axis_tdata[2*WIDTH-1:WIDTH]
                                          : s_axis_tdata[2*WIDTH-1:WIDTH];
    assign mbig = (mx < my) ? my : mx;
    assign msml = (mx < my) ? mx : my;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Drive the shared unit
    always_comb begin
        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        opa       = big_reg;
        opb       = sml_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            cmd.start = (msml != '0) && !(s_axis_tuser == FUNC_LCM && mbig == '0);
            opa = mbig;
            opb = msml;
        end else if (state_reg == S_STN && sml_reg == '0 && func_reg == FUNC_LCM) begin
            cmd.start = 1'b1;
            opa = ax_reg;
            opb = big_reg << com_reg;
        end else if (state_reg == S_DIV && done) begin
            cmd.start = 1'b1;
            cmd.op    = OP_MUL;
            opa = quo;
            opb = ay_reg;
        end
    end

    glu_divmul #(.WIDTH(WIDTH)) u_divmul (
        .aclk, .aresetn, .cmd, .opa, .opb, .done, .quo, .rem, .prod
    );

    // Sequence one word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_axis_tvalid <= 1'b0;
        end else begin
            // Raise valid when a word moves into the output register, drop it once taken
            if (state_reg == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    func_reg <= s_axis_tuser;
                    ax_reg   <= mx;
                    ay_reg   <= my;
                    big_reg  <= mbig;
                    sml_reg  <= msml;
                    com_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    if (s_axis_tuser == FUNC_LCM && msml == '0) begin
                        res_reg <= '0;
                        state_reg <= S_OUT;
                    end else if (msml == '0) begin
                        res_reg <= mbig;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD: if (done) begin
                    big_reg <= rem;
                    if (rem == '0) begin
                        // gcd is the smaller operand
                        big_reg <= sml_reg;
                        sml_reg <= '0;
                    end
                    state_reg <= S_STN;
                end
                S_STN: begin
                    // Strip common twos, then strip / subtract
                    if (sml_reg == '0) begin
                        res_reg   <= big_reg << com_reg;
                        state_reg <= (func_reg == FUNC_LCM) ? S_DIV : S_OUT;
                    end else if (!big_reg[0] && !sml_reg[0]) begin
                        big_reg <= big_reg >> 1;
                        sml_reg <= sml_reg >> 1;
                        com_reg <= com_reg + 1'b1;
                    end else if (!big_reg[0]) begin
                        big_reg <= big_reg >> 1;
                    end else if (!sml_reg[0]) begin
                        sml_reg <= sml_reg >> 1;
                    end else if (big_reg > sml_reg) begin
                        sml_reg <= big_reg - sml_reg;
                        big_reg <= sml_reg;
                    end else begin
                        sml_reg <= sml_reg - big_reg;
                    end
                end
                S_DIV: if (done) state_reg <= S_MUL;
                S_MUL: if (done) begin
                    if (prod > {{(WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}}) begin
                        ovf_reg <= 1'b1;
                        res_reg <= '0;
                    end else begin
                        res_reg <= prod[WIDTH-1:0];
                    end
                    state_reg <= S_OUT;
                end
                // Load the output register once it is free
                S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
                    mdata_reg <= res_reg;
                    muser_reg <= ovf_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = mdata_reg;
    assign m_axis_tuser = muser_reg;

endmodule

### rtl/glu_checker.sv
module glu_checker #(
    parameter int WIDTH = 32
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [WIDTH-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("ovf nonzero");
    a_user_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
        else $error("overflow flag changed while stalled");
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");

endmodule

bind gcd_lcm_unit glu_checker #(.WIDTH(WIDTH)) u_glu_checker (
    .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
